// File: hdl/bmrd_pkg.sv
// ----------------------------------------------------------------------------
// Battery monitor record decoder: shared types and constants
// Limit register map, register reset values, decoded result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bmrd_pkg;

  // Stream and configuration port widths
  localparam int unsigned S_TDATA_W   = 128;
  localparam int unsigned M_TDATA_W   = 120;
  localparam int unsigned M_TUSER_W   = 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 22;

  // Limit register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NOMINAL_AUX_MODE  = 3'd0,
    REG_BATTERY_VOLTS_MIN = 3'd1,
    REG_BATTERY_VOLTS_MAX = 3'd2,
    REG_AUX_VALUE_MIN     = 3'd3,
    REG_AUX_VALUE_MAX     = 3'd4,
    REG_CURRENT_MIN       = 3'd5,
    REG_CURRENT_MAX       = 3'd6,
    REG_CHARGE_USED_MAX   = 3'd7
  } cfg_index_t;

  // Aux mode codes
  localparam logic [1:0] AUX_MODE_AUX_VOLTS = 2'd0;
  localparam logic [1:0] AUX_MODE_NONE      = 2'd3;

  // Alarm class codes
  localparam logic [3:0] ALARM_CLASS_NONE  = 4'd0;
  localparam logic [3:0] ALARM_CLASS_MULTI = 4'd15;
  localparam int unsigned ALARM_NAMED      = 14;

  // Value constants
  localparam logic signed [17:0] AUX_NONE_VALUE  = 18'sd99999;
  localparam logic [9:0]         SOC_RAW_LIMIT   = 10'd1000;
  localparam logic [13:0]        SOC_CLAMP_VALUE = 14'd9999;
  localparam logic [13:0]        SOC_LOW_LIMIT   = 14'd0;
  localparam logic [13:0]        SOC_HIGH_LIMIT  = 14'd1000;

  // Register reset values
  localparam logic [1:0]         RST_NOMINAL_AUX_MODE  = 2'd0;
  localparam logic signed [15:0] RST_BATTERY_VOLTS_MIN = 16'sh8000;
  localparam logic signed [15:0] RST_BATTERY_VOLTS_MAX = 16'sh7FFF;
  localparam logic signed [17:0] RST_AUX_VALUE_MIN     = 18'sh38000;
  localparam logic signed [17:0] RST_AUX_VALUE_MAX     = 18'sd99999;
  localparam logic signed [21:0] RST_CURRENT_MIN       = 22'sh200000;
  localparam logic signed [21:0] RST_CURRENT_MAX       = 22'sh1FFFFF;
  localparam logic [19:0]        RST_CHARGE_USED_MAX   = 20'hFFFFF;

  // Limit register set
  typedef struct packed {
    logic [1:0]         nominal_aux_mode;
    logic signed [15:0] battery_volts_min;
    logic signed [15:0] battery_volts_max;
    logic signed [17:0] aux_value_min;
    logic signed [17:0] aux_value_max;
    logic signed [21:0] current_min;
    logic signed [21:0] current_max;
    logic [19:0]        charge_used_max;
  } cfg_t;

  // One decoded record
  typedef struct packed {
    logic [15:0]        minutes_to_go;
    logic signed [15:0] battery_volts;
    logic [1:0]         aux_kind;
    logic signed [17:0] aux_reading;
    logic signed [21:0] battery_current;
    logic [19:0]        charge_used;
    logic [13:0]        charge_state;
    logic [3:0]         alarm_class;
    logic [5:0]         unavailable_mask;
    logic [2:0]         dud_count;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/battery_monitor_record_decoder_unit.sv
// ----------------------------------------------------------------------------
// Battery monitor record decoder unit
// Decodes one 16-byte record per transaction into raw device fields, flags
// and a plausibility count checked against the limit registers.
//
//   channel   dir  handshake                       payload
//   s_axis    in   s_axis_tvalid / s_axis_tready   tdata: record_low, record_high
//   m_axis    out  m_axis_tvalid / m_axis_tready   tdata: decoded fields,
//                                                  tuser: aux_kind
//   cfg       in   cfg_we (no wait)                cfg_index, cfg_data
//
// One record per cycle sustained while m_axis does not stall. Records pass the
// input register, then decode into the result register. Each stage advances
// when the stage after it is empty or being drained, so a stall on m_axis holds
// both stages and s_axis_tready falls only when both are full. Synchronous reset
// empties both stages and loads the limit registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_monitor_record_decoder_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // s_axis tdata: record_low [63:0], record_high [127:64]
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [bmrd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // m_axis tdata: minutes_to_go [15:0], battery_volts [31:16],
  //   aux_reading [49:32], battery_current [71:50], charge_used [91:72],
  //   charge_state [105:92], alarm_class [109:106], unavailable_mask [115:110],
  //   dud_count [118:116], zero fill [119]
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [bmrd_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // m_axis tuser: aux_kind [1:0]
  output logic [bmrd_pkg::M_TUSER_W-1:0]          m_axis_tuser,
  // Limit register writes
  input  wire logic                               cfg_we,
  input  wire logic [bmrd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [bmrd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bmrd_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  logic [63:0] in_low;
  logic [63:0] in_high;
  logic        out_valid;
  result_t     res;
  result_t     res_next;
  logic        out_advance;
  logic        in_advance;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_aux_mode  <= RST_NOMINAL_AUX_MODE;
      cfg.battery_volts_min <= RST_BATTERY_VOLTS_MIN;
      cfg.battery_volts_max <= RST_BATTERY_VOLTS_MAX;
      cfg.aux_value_min     <= RST_AUX_VALUE_MIN;
      cfg.aux_value_max     <= RST_AUX_VALUE_MAX;
      cfg.current_min       <= RST_CURRENT_MIN;
      cfg.current_max       <= RST_CURRENT_MAX;
      cfg.charge_used_max   <= RST_CHARGE_USED_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_NOMINAL_AUX_MODE:  cfg.nominal_aux_mode  <= cfg_data[1:0];
        REG_BATTERY_VOLTS_MIN: cfg.battery_volts_min <= $signed(cfg_data[15:0]);
        REG_BATTERY_VOLTS_MAX: cfg.battery_volts_max <= $signed(cfg_data[15:0]);
        REG_AUX_VALUE_MIN:     cfg.aux_value_min     <= $signed(cfg_data[17:0]);
        REG_AUX_VALUE_MAX:     cfg.aux_value_max     <= $signed(cfg_data[17:0]);
        REG_CURRENT_MIN:       cfg.current_min       <= $signed(cfg_data[21:0]);
        REG_CURRENT_MAX:       cfg.current_max       <= $signed(cfg_data[21:0]);
        REG_CHARGE_USED_MAX:   cfg.charge_used_max   <= cfg_data[19:0];
        default:               cfg.charge_used_max   <= cfg.charge_used_max;
      endcase
    end
  end

  // Stage flow control
  assign out_advance   = !out_valid || m_axis_tready;
  assign in_advance    = !in_valid || out_advance;
  assign s_axis_tready = in_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_advance) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && s_axis_tvalid) begin
      in_low  <= s_axis_tdata[63:0];
      in_high <= s_axis_tdata[127:64];
    end
  end

  // Decode
  bmrd_decode u_decode (
    .record_low  (in_low),
    .record_high (in_high),
    .cfg         (cfg),
    .result      (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      res <= res_next;
    end
  end

  // Drive the result channel
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = res.aux_kind;
  assign m_axis_tdata  = {1'b0, res.dud_count, res.unavailable_mask, res.alarm_class,
                          res.charge_state, res.charge_used, res.battery_current,
                          res.aux_reading, res.battery_volts, res.minutes_to_go};

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with the result register empty");

  a_dud_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.dud_count <= 3'd6))
    else $error("implausible count above six");

  a_soc_clamp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.unavailable_mask[5] |-> (res.charge_state == SOC_CLAMP_VALUE))
    else $error("unavailable state of charge not clamped");

  a_aux_none: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (res.aux_kind == AUX_MODE_NONE) |->
      (res.aux_reading == AUX_NONE_VALUE) && !res.unavailable_mask[2])
    else $error("aux mode none decoded wrongly");

endmodule

`default_nettype wire

// File: hdl/bmrd_decode.sv
// ----------------------------------------------------------------------------
// Battery monitor record decoder: field unpack and plausibility check
// Splits one 16-byte record into its fields, flags unavailable values,
// classifies the alarm word and counts values outside the limit registers or the fixed charge state range.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrd_decode (
  input  wire logic [63:0]      record_low,
  input  wire logic [63:0]      record_high,
  input  wire bmrd_pkg::cfg_t   cfg,
  output bmrd_pkg::result_t     result
);
  import bmrd_pkg::*;

  logic [15:0]        ttg;
  logic [15:0]        vraw;
  logic [15:0]        alarms;
  logic [15:0]        araw;
  logic [1:0]         mode;
  logic [21:0]        craw;
  logic [19:0]        ah;
  logic [9:0]         socraw;
  logic signed [17:0] aux;
  logic [13:0]        soc;
  logic               na_t, na_v, na_a, na_c, na_ah, na_soc;
  logic               alarm_any, alarm_single;
  logic [3:0]         alarm_idx;
  logic [3:0]         alarm_class;
  logic               bad_mode, bad_v, bad_a, bad_c, bad_soc, bad_ah;

  // Slice the record
  assign ttg    = record_low[15:0];
  assign vraw   = record_low[31:16];
  assign alarms = record_low[47:32];
  assign araw   = record_low[63:48];
  assign mode   = record_high[1:0];
  assign craw   = record_high[23:2];
  assign ah     = record_high[43:24];
  assign socraw = record_high[53:44];

  // Interpret the aux value by mode
  always_comb begin
    unique case (mode)
      AUX_MODE_AUX_VOLTS: begin
        aux  = {{2{araw[15]}}, araw};
        na_a = (araw[14:0] == 15'h7FFF);
      end
      AUX_MODE_NONE: begin
        aux  = AUX_NONE_VALUE;
        na_a = 1'b0;
      end
      default: begin
        aux  = $signed({2'b00, araw});
        na_a = (araw == 16'hFFFF);
      end
    endcase
  end

  // Unavailable flags and state of charge clamp
  assign na_t   = (ttg == 16'hFFFF);
  assign na_v   = (vraw[14:0] == 15'h7FFF);
  assign na_c   = (craw[20:0] == 21'h1FFFFF);
  assign na_ah  = (ah == 20'hFFFFF);
  assign na_soc = (socraw == 10'h3FF);
  assign soc    = (socraw > SOC_RAW_LIMIT) ? SOC_CLAMP_VALUE : {4'b0000, socraw};

  // Classify the alarm word: a lone bit among the named ones gives its index
  assign alarm_any    = (alarms != 16'h0000);
  assign alarm_single = alarm_any && ((alarms & (alarms - 16'h0001)) == 16'h0000);

  always_comb begin
    alarm_idx = ALARM_CLASS_NONE;
    for (int i = 0; i < ALARM_NAMED; i++) begin
      if (alarms[i]) begin
        alarm_idx = 4'(i + 1);
      end
    end
  end

  always_comb begin
    if (!alarm_any) begin
      alarm_class = ALARM_CLASS_NONE;
    end else if (alarm_single) begin
      alarm_class = alarm_idx;
    end else begin
      alarm_class = ALARM_CLASS_MULTI;
    end
  end

  // Plausibility checks; an unavailable value is never counted
  assign bad_mode = (mode != cfg.nominal_aux_mode);
  assign bad_v    = !na_v && (($signed(vraw) < cfg.battery_volts_min) ||
                              ($signed(vraw) > cfg.battery_volts_max));
  assign bad_a    = !na_a && ((aux < cfg.aux_value_min) || (aux > cfg.aux_value_max));
  assign bad_c    = !na_c && (($signed(craw) < cfg.current_min) ||
                              ($signed(craw) > cfg.current_max));
  assign bad_soc  = !na_soc && ((soc < SOC_LOW_LIMIT) || (soc > SOC_HIGH_LIMIT));
  assign bad_ah   = !na_ah && (ah > cfg.charge_used_max);

  // Assemble the result
  always_comb begin
    result.minutes_to_go    = ttg;
    result.battery_volts    = $signed(vraw);
    result.aux_kind         = mode;
    result.aux_reading      = aux;
    result.battery_current  = $signed(craw);
    result.charge_used      = ah;
    result.charge_state     = soc;
    result.alarm_class      = alarm_class;
    result.unavailable_mask = {na_soc, na_ah, na_c, na_a, na_v, na_t};
    result.dud_count        = {2'b00, bad_mode} + {2'b00, bad_v} + {2'b00, bad_a} +
                              {2'b00, bad_c} + {2'b00, bad_soc} + {2'b00, bad_ah};
  end

endmodule

`default_nettype wire

// File: tb/tb_battery_monitor_record_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery monitor record decoder unit testbench
// Streams records through the decoder under several limit register settings
// and compares every decoded transaction, field by field, with a predictor
// kept in step with the limit registers. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb_battery_monitor_record_decoder_unit;
  import bmrd_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;

  // Aux mode codes not named in the package
  localparam logic [1:0] AUX_MODE_MIDPOINT = 2'd1;
  localparam logic [1:0] AUX_MODE_KELVIN   = 2'd2;

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [M_TUSER_W-1:0]   m_axis_tuser;
  logic                   cfg_we        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;

  cfg_t        limit_regs;
  result_t     pending_decodes[$];
  int unsigned mismatches       = 0;
  int unsigned records_sent     = 0;
  int unsigned results_checked  = 0;
  int unsigned settings_loaded  = 0;
  int unsigned idle_cycles      = 0;
  int unsigned ready_hold       = 0;
  bit          source_gaps      = 1'b1;
  bit          sink_stalls      = 1'b1;

  battery_monitor_record_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Assemble a 128-bit record from its raw fields
  function automatic logic [127:0] pack_record(
    input logic [15:0] ttg, input logic [15:0] volts, input logic [15:0] alarms,
    input logic [15:0] aux, input logic [1:0] mode, input logic [21:0] current,
    input logic [19:0] charge, input logic [9:0] soc, input logic [9:0] spare
  );
    return {spare, soc, charge, current, mode, aux, alarms, volts, ttg};
  endfunction

  // Predict the decoded transaction for one record under the current limits
  function automatic result_t decode_record(input logic [127:0] rec);
    result_t     r;
    logic [15:0] alarms;
    logic [15:0] aux_raw;
    logic [9:0]  soc_raw;
    logic        na_volts, na_aux, na_current, na_charge, na_soc;
    int unsigned duds;
    alarms  = rec[47:32];
    aux_raw = rec[63:48];
    soc_raw = rec[117:108];
    r.minutes_to_go   = rec[15:0];
    r.battery_volts   = rec[31:16];
    r.aux_kind        = rec[65:64];
    r.battery_current = rec[87:66];
    r.charge_used     = rec[107:88];
    r.charge_state    = (soc_raw > SOC_RAW_LIMIT) ? SOC_CLAMP_VALUE : {4'd0, soc_raw};

    case (r.aux_kind)
      AUX_MODE_AUX_VOLTS: begin
        r.aux_reading = {{2{aux_raw[15]}}, aux_raw};
        na_aux        = (aux_raw[14:0] == 15'h7FFF);
      end
      AUX_MODE_NONE: begin
        r.aux_reading = AUX_NONE_VALUE;
        na_aux        = 1'b0;
      end
      default: begin
        r.aux_reading = {2'b00, aux_raw};
        na_aux        = (aux_raw == 16'hFFFF);
      end
    endcase

    na_volts   = (rec[30:16] == 15'h7FFF);
    na_current = (rec[86:66] == 21'h1FFFFF);
    na_charge  = (r.charge_used == 20'hFFFFF);
    na_soc     = (soc_raw == 10'h3FF);
    r.unavailable_mask = {na_soc, na_charge, na_current, na_aux, na_volts,
                          rec[15:0] == 16'hFFFF};

    // Single alarms in the top two bits have no name and read as none
    r.alarm_class = ALARM_CLASS_NONE;
    if ($countones(alarms) > 1) begin
      r.alarm_class = ALARM_CLASS_MULTI;
    end else if ($countones(alarms) == 1) begin
      for (int i = 0; i < ALARM_NAMED; i++)
        if (alarms[i]) r.alarm_class = 4'(i + 1);
    end

    // Count implausible values; unavailable ones are never counted
    duds = 0;
    if (r.aux_kind != limit_regs.nominal_aux_mode) duds++;
    if (!na_volts && ($signed(r.battery_volts) < $signed(limit_regs.battery_volts_min) ||
                      $signed(r.battery_volts) > $signed(limit_regs.battery_volts_max)))
      duds++;
    if (!na_aux && ($signed(r.aux_reading) < $signed(limit_regs.aux_value_min) ||
                    $signed(r.aux_reading) > $signed(limit_regs.aux_value_max)))
      duds++;
    if (!na_current && ($signed(r.battery_current) < $signed(limit_regs.current_min) ||
                        $signed(r.battery_current) > $signed(limit_regs.current_max)))
      duds++;
    if (!na_soc && (r.charge_state < SOC_LOW_LIMIT || r.charge_state > SOC_HIGH_LIMIT))
      duds++;
    if (!na_charge && r.charge_used > limit_regs.charge_used_max) duds++;
    r.dud_count = 3'(duds);
    return r;
  endfunction

  // Random record, biased toward unavailable markers and limit boundaries
  function automatic logic [127:0] random_record();
    logic [127:0] rec;
    rec = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 7) == 0) rec[15:0] = 16'hFFFF;
    case ($urandom_range(0, 7))
      0: rec[31:16] = {1'($urandom), 15'h7FFF};
      1: rec[31:16] = limit_regs.battery_volts_min;
      2: rec[31:16] = limit_regs.battery_volts_max;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: rec[47:32] = 16'h0000;
      1, 2: rec[47:32] = 16'h0001 << $urandom_range(0, 15);
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: rec[63:48] = {1'($urandom), 15'h7FFF};
      1: rec[63:48] = 16'hFFFF;
      2: rec[63:48] = limit_regs.aux_value_min[15:0];
      3: rec[63:48] = limit_regs.aux_value_max[15:0];
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: rec[87:66] = {1'($urandom), 21'h1FFFFF};
      1: rec[87:66] = limit_regs.current_min;
      2: rec[87:66] = limit_regs.current_max;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: rec[107:88] = 20'hFFFFF;
      1: rec[107:88] = limit_regs.charge_used_max;
      2: rec[107:88] = limit_regs.charge_used_max + 20'd1;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0, 1: rec[117:108] = 10'(995 + $urandom_range(0, 10));
      2: rec[117:108] = 10'h3FF;
      default: ;
    endcase
    return rec;
  endfunction

  // Gap before the next record: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!source_gaps || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one record and hold it until the decoder accepts the transaction
  task automatic send_record(input logic [127:0] rec);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rec;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_decodes.push_back(decode_record(rec));
    records_sent++;
  endtask

  task automatic wait_idle();
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one limit register; bits above its width carry junk that must be dropped
  task automatic write_limit(input cfg_index_t idx, input logic [21:0] value);
    int unsigned width;
    logic [21:0] keep;
    logic [21:0] word;
    case (idx)
      REG_NOMINAL_AUX_MODE: width = 2;
      REG_BATTERY_VOLTS_MIN, REG_BATTERY_VOLTS_MAX: width = 16;
      REG_AUX_VALUE_MIN, REG_AUX_VALUE_MAX: width = 18;
      REG_CHARGE_USED_MAX: width = 20;
      default: width = 22;
    endcase
    keep = (22'd1 << width) - 22'd1;
    word = (value & keep) | (22'($urandom) & ~keep);
    case (idx)
      REG_NOMINAL_AUX_MODE:  limit_regs.nominal_aux_mode  = word[1:0];
      REG_BATTERY_VOLTS_MIN: limit_regs.battery_volts_min = word[15:0];
      REG_BATTERY_VOLTS_MAX: limit_regs.battery_volts_max = word[15:0];
      REG_AUX_VALUE_MIN:     limit_regs.aux_value_min     = word[17:0];
      REG_AUX_VALUE_MAX:     limit_regs.aux_value_max     = word[17:0];
      REG_CURRENT_MIN:       limit_regs.current_min       = word;
      REG_CURRENT_MAX:       limit_regs.current_max       = word;
      default:               limit_regs.charge_used_max   = word[19:0];
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the decoder, then load a full set of limits
  task automatic load_limits(input logic [1:0] mode, input int volts_lo, input int volts_hi,
                             input int aux_lo, input int aux_hi, input int cur_lo,
                             input int cur_hi, input int charge_hi);
    wait_idle();
    write_limit(REG_NOMINAL_AUX_MODE, 22'(mode));
    write_limit(REG_BATTERY_VOLTS_MIN, 22'(volts_lo));
    write_limit(REG_BATTERY_VOLTS_MAX, 22'(volts_hi));
    write_limit(REG_AUX_VALUE_MIN, 22'(aux_lo));
    write_limit(REG_AUX_VALUE_MAX, 22'(aux_hi));
    write_limit(REG_CURRENT_MIN, 22'(cur_lo));
    write_limit(REG_CURRENT_MAX, 22'(cur_hi));
    write_limit(REG_CHARGE_USED_MAX, 22'(charge_hi));
    settings_loaded++;
  endtask

  // Random records, with occasional stretches at full rate on both sides
  task automatic run_random_records(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        source_gaps = ($urandom_range(0, 3) != 0);
        sink_stalls = source_gaps;
      end
      send_record(random_record());
    end
    s_axis_tvalid <= 1'b0;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // Field extremes, unavailable markers, aux modes and alarm classes at reset limits
  task automatic test_special_records();
    send_record(pack_record(16'h0000, 16'h0000, 16'h0000, 16'h0000, AUX_MODE_AUX_VOLTS,
                            22'h000000, 20'h00000, 10'd0, 10'h000));
    send_record(pack_record(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, AUX_MODE_NONE,
                            22'h3FFFFF, 20'hFFFFF, 10'h3FF, 10'h3FF));
    send_record(pack_record(16'h1234, 16'h7FFF, 16'h0001, 16'h7FFF, AUX_MODE_AUX_VOLTS,
                            22'h000001, 20'h00000, 10'd500, 10'h000));
    send_record(pack_record(16'h0000, 16'h8000, 16'h2000, 16'hFFFF, AUX_MODE_AUX_VOLTS,
                            22'h200000, 20'h00001, 10'd1000, 10'h000));
    send_record(pack_record(16'hFFFE, 16'h7FFE, 16'h4000, 16'hFFFF, AUX_MODE_MIDPOINT,
                            22'h1FFFFE, 20'hFFFFE, 10'd1001, 10'h000));
    send_record(pack_record(16'h0001, 16'h0001, 16'h8000, 16'h7FFF, AUX_MODE_MIDPOINT,
                            22'h1FFFFF, 20'h00001, 10'd1, 10'h000));
    send_record(pack_record(16'h0000, 16'hFFFE, 16'h0003, 16'h8000, AUX_MODE_KELVIN,
                            22'h3FFFFF, 20'hFFFFF, 10'h3FF, 10'h000));
    send_record(pack_record(16'h00FF, 16'h0100, 16'h0040, 16'hFFFE, AUX_MODE_KELVIN,
                            22'h2AAAAA, 20'h55555, 10'd1002, 10'h155));
    send_record(pack_record(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, AUX_MODE_NONE,
                            22'h000000, 20'h00000, 10'd0, 10'h000));
    send_record(pack_record(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, AUX_MODE_NONE,
                            22'h000000, 20'h00000, 10'd999, 10'h2AA));
    send_record(pack_record(16'h0000, 16'h0000, 16'h0000, 16'h0000, AUX_MODE_AUX_VOLTS,
                            22'h000000, 20'h00000, 10'd0, 10'h3FF));
    send_record(pack_record(16'h8000, 16'h8001, 16'hC000, 16'h8000, AUX_MODE_AUX_VOLTS,
                            22'h200001, 20'h80000, 10'd1023 - 10'd1, 10'h000));
    send_record(pack_record(16'h7FFF, 16'hFFFF, 16'h1000, 16'h7FFE, AUX_MODE_AUX_VOLTS,
                            22'h1FFFFF, 20'hFFFFF, 10'd1000, 10'h200));
    run_random_records(100);
  endtask

  // Every range collapsed to zero; most values count as implausible
  task automatic test_tight_limits();
    load_limits(AUX_MODE_NONE, 0, 0, 0, 0, 0, 0, 0);
    run_random_records(80);
  endtask

  // Volts, aux and current ranges inverted at the extremes, charge used limited to zero
  task automatic test_inverted_limits();
    load_limits(AUX_MODE_MIDPOINT, 32767, -32768, 99999, -32768, 2097151, -2097152, 0);
    run_random_records(60);
  endtask

  // Widest legal ranges; only the aux mode and state of charge checks can fire
  task automatic test_widest_limits();
    load_limits(AUX_MODE_KELVIN, -32768, 32767, -32768, 99999, -2097152, 2097151, 1048575);
    run_random_records(60);
  endtask

  // Random limit sets, mostly ordered and sometimes inverted
  task automatic test_random_limits();
    int volts_lo, volts_hi, aux_lo, aux_hi, cur_lo, cur_hi, swap;
    for (int pass_idx = 0; pass_idx < 4; pass_idx++) begin
      volts_lo = int'($urandom_range(0, 65535)) - 32768;
      volts_hi = int'($urandom_range(0, 65535)) - 32768;
      aux_lo   = int'($urandom_range(0, 132767)) - 32768;
      aux_hi   = int'($urandom_range(0, 132767)) - 32768;
      cur_lo   = int'($urandom_range(0, 4194303)) - 2097152;
      cur_hi   = int'($urandom_range(0, 4194303)) - 2097152;
      if (volts_lo > volts_hi && $urandom_range(0, 7) != 0) begin
        swap = volts_lo; volts_lo = volts_hi; volts_hi = swap;
      end
      if (aux_lo > aux_hi && $urandom_range(0, 7) != 0) begin
        swap = aux_lo; aux_lo = aux_hi; aux_hi = swap;
      end
      if (cur_lo > cur_hi && $urandom_range(0, 7) != 0) begin
        swap = cur_lo; cur_lo = cur_hi; cur_hi = swap;
      end
      load_limits(2'($urandom), volts_lo, volts_hi, aux_lo, aux_hi, cur_lo, cur_hi,
                  int'($urandom_range(0, 1048575)));
      run_random_records(75);
    end
  endtask

  // Downstream ready: random stalls, mostly short and a few long
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (!sink_stalls) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold = $urandom_range(0, 4);
    end
  end

  task automatic check_field(input string name, input logic [21:0] want,
                             input logic [21:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each decoded transaction with the oldest prediction
  always @(posedge clk) begin : result_checker
    result_t want;
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.minutes_to_go    = m_axis_tdata[15:0];
      got.battery_volts    = m_axis_tdata[31:16];
      got.aux_reading      = m_axis_tdata[49:32];
      got.battery_current  = m_axis_tdata[71:50];
      got.charge_used      = m_axis_tdata[91:72];
      got.charge_state     = m_axis_tdata[105:92];
      got.alarm_class      = m_axis_tdata[109:106];
      got.unavailable_mask = m_axis_tdata[115:110];
      got.dud_count        = m_axis_tdata[118:116];
      got.aux_kind         = m_axis_tuser;
      if (pending_decodes.size() == 0) begin
        $error("decoded transaction with no record pending");
        mismatches++;
      end else begin
        want = pending_decodes.pop_front();
        check_field("minutes_to_go", want.minutes_to_go, got.minutes_to_go);
        check_field("battery_volts", want.battery_volts, got.battery_volts);
        check_field("aux_kind", want.aux_kind, got.aux_kind);
        check_field("aux_reading", want.aux_reading, got.aux_reading);
        check_field("battery_current", want.battery_current, got.battery_current);
        check_field("charge_used", want.charge_used, got.charge_used);
        check_field("charge_state", want.charge_state, got.charge_state);
        check_field("alarm_class", want.alarm_class, got.alarm_class);
        check_field("unavailable_mask", want.unavailable_mask, got.unavailable_mask);
        check_field("dud_count", want.dud_count, got.dud_count);
        results_checked++;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("battery_monitor_record_decoder_unit verification failed");
      $finish;
    end
  end

  initial begin
    limit_regs.nominal_aux_mode  = RST_NOMINAL_AUX_MODE;
    limit_regs.battery_volts_min = RST_BATTERY_VOLTS_MIN;
    limit_regs.battery_volts_max = RST_BATTERY_VOLTS_MAX;
    limit_regs.aux_value_min     = RST_AUX_VALUE_MIN;
    limit_regs.aux_value_max     = RST_AUX_VALUE_MAX;
    limit_regs.current_min       = RST_CURRENT_MIN;
    limit_regs.current_max       = RST_CURRENT_MAX;
    limit_regs.charge_used_max   = RST_CHARGE_USED_MAX;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_records();
    test_tight_limits();
    test_inverted_limits();
    test_widest_limits();
    test_random_limits();

    wait_idle();
    if (pending_decodes.size() != 0) begin
      $error("%0d predicted transactions never arrived", pending_decodes.size());
      mismatches++;
    end
    $display("Decoded %0d of %0d records checked, over reset limits and %0d loaded limit sets",
             results_checked, records_sent, settings_loaded);
    $display("Covered aux modes, unavailable markers, alarm classes, charge clamping, range edges");
    if (mismatches == 0)
      $display("battery_monitor_record_decoder_unit verification clean");
    else
      $display("battery_monitor_record_decoder_unit verification failed");
    $finish;
  end

endmodule
